@@ src/wavd_pkg.sv @@
// ----------------------------------------------------------------------------
// wavd_pkg
// Shared types and constants for the WAV to unsigned 8-bit mono PCM decoder.
// ----------------------------------------------------------------------------
package wavd_pkg;

  localparam int unsigned MAX_FRAMES_W = 17;

  localparam logic [MAX_FRAMES_W-1:0] MAX_FRAMES_RST = 17'h10000;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_HEADER  = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ST_NO_SAMPLES  = 2'd3;

  localparam logic [5:0] MIN_FILE_BYTES = 6'd44;
  localparam logic [4:0] FMT_MIN_BYTES  = 5'd16;

  typedef struct packed {
    logic                    has_result;
    logic [7:0]              sample;
    logic                    sample_valid;
    logic                    done;
    logic [1:0]              status;
    logic [31:0]             rate;
    logic [MAX_FRAMES_W-1:0] count;
  } res_t;

  // byte idx of a four-character tag, first character in the top byte
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    return tag[{~idx, 3'b000} +: 8];
  endfunction

endpackage

@@ src/wavd_parse.sv @@
// ----------------------------------------------------------------------------
// wavd_parse
// RIFF/WAVE chunk walker and frame mixer: parse state and one-byte step.
// ----------------------------------------------------------------------------
module wavd_parse import wavd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              file_byte,
  input  logic                    end_of_file,
  input  logic [MAX_FRAMES_W-1:0] max_frames,
  output res_t                    res
);

  typedef enum logic [2:0] {
    PH_RIFF, PH_TAG, PH_SIZE, PH_FMT, PH_DATA, PH_SKIP, PH_STOP
  } phase_t;

  phase_t                  phase_r,  phase_nxt;
  logic [5:0]              pos_r,    pos_nxt;
  logic [31:0]             tag_r,    tag_nxt;
  logic [32:0]             rem_r,    rem_nxt;
  logic [15:0]             chan_r,   chan_nxt;
  logic [31:0]             rate_r,   rate_nxt;
  logic [15:0]             bits_r,   bits_nxt;
  logic [2:0]              fbytes_r, fbytes_nxt;
  logic [1:0]              fidx_r,   fidx_nxt;
  logic [MAX_FRAMES_W-1:0] femit_r,  femit_nxt;
  logic [1:0]              err_r,    err_nxt;
  logic [4:0]              foff_r,   foff_nxt;
  logic [3:0][7:0]         fbuf_r,   fbuf_nxt;

  logic [32:0] rem_dec;
  logic [31:0] size_w;
  logic [32:0] size_pad;
  logic        smp_valid;
  logic [7:0]  smp;
  logic [1:0]  status;

  function automatic logic [7:0] mix_frame(input logic [3:0][7:0] f, input logic w16,
                                           input logic stereo);
    logic [8:0]  sum8;
    logic [16:0] sum16;
    logic [15:0] v;
    sum8  = {1'b0, f[0]} + {1'b0, f[1]};
    sum16 = {f[1][7], f[1], f[0]} + {f[3][7], f[3], f[2]};
    sum16 = sum16 + {16'd0, sum16[16]};
    v     = stereo ? sum16[16:1] : {f[1], f[0]};
    if (!w16) begin
      return stereo ? sum8[8:1] : f[0];
    end
    return v[15:8] ^ 8'h80;
  endfunction

  assign rem_dec  = rem_r - 33'd1;
  assign size_w   = rem_r[31:0] | (32'(file_byte) << {fidx_r, 3'b000});
  assign size_pad = {1'b0, size_w} + {32'd0, size_w[0]};

  always_comb begin
    phase_nxt  = phase_r;
    tag_nxt    = tag_r;
    rem_nxt    = rem_r;
    chan_nxt   = chan_r;
    rate_nxt   = rate_r;
    bits_nxt   = bits_r;
    fbytes_nxt = fbytes_r;
    fidx_nxt   = fidx_r;
    femit_nxt  = femit_r;
    err_nxt    = err_r;
    foff_nxt   = foff_r;
    fbuf_nxt   = fbuf_r;
    smp_valid  = 1'b0;
    smp        = 8'd0;
    pos_nxt    = (pos_r == MIN_FILE_BYTES) ? pos_r : pos_r + 6'd1;

    case (phase_r)
      PH_RIFF: begin
        if (pos_r < 6'd4 && file_byte != tag_byte(TAG_RIFF, pos_r[1:0])) begin
          err_nxt   = ST_BAD_HEADER;
          phase_nxt = PH_STOP;
        end else if (pos_r >= 6'd8 && pos_r < 6'd12 &&
                     file_byte != tag_byte(TAG_WAVE, pos_r[1:0])) begin
          err_nxt   = ST_BAD_HEADER;
          phase_nxt = PH_STOP;
        end else if (pos_r >= 6'd11) begin
          phase_nxt = PH_TAG;
          fidx_nxt  = 2'd0;
        end
      end
      PH_TAG: begin
        tag_nxt  = {tag_r[23:0], file_byte};
        fidx_nxt = fidx_r + 2'd1;
        if (fidx_r == 2'd3) begin
          phase_nxt = PH_SIZE;
          rem_nxt   = 33'd0;
        end
      end
      PH_SIZE: begin
        rem_nxt  = {1'b0, size_w};
        fidx_nxt = fidx_r + 2'd1;
        if (fidx_r == 2'd3) begin
          fidx_nxt = 2'd0;
          if (tag_r == TAG_FMT) begin
            if (size_w < 32'(FMT_MIN_BYTES)) begin
              err_nxt   = ST_UNSUPPORTED;
              phase_nxt = PH_STOP;
            end else begin
              rem_nxt   = size_pad;
              foff_nxt  = 5'd0;
              phase_nxt = PH_FMT;
            end
          end else if (tag_r == TAG_DATA) begin
            if ((chan_r != 16'd1 && chan_r != 16'd2) ||
                (bits_r != 16'd8 && bits_r != 16'd16) || rate_r == 32'd0) begin
              err_nxt   = ST_UNSUPPORTED;
              phase_nxt = PH_STOP;
            end else begin
              if (bits_r == 16'd16) begin
                fbytes_nxt = (chan_r == 16'd2) ? 3'd4 : 3'd2;
              end else begin
                fbytes_nxt = (chan_r == 16'd2) ? 3'd2 : 3'd1;
              end
              phase_nxt = (size_w != 32'd0) ? PH_DATA : PH_STOP;
            end
          end else begin
            rem_nxt   = size_pad;
            phase_nxt = (size_pad != 33'd0) ? PH_SKIP : PH_TAG;
          end
        end
      end
      PH_FMT: begin
        case (foff_r)
          5'd2:    chan_nxt[7:0]   = file_byte;
          5'd3:    chan_nxt[15:8]  = file_byte;
          5'd4:    rate_nxt[7:0]   = file_byte;
          5'd5:    rate_nxt[15:8]  = file_byte;
          5'd6:    rate_nxt[23:16] = file_byte;
          5'd7:    rate_nxt[31:24] = file_byte;
          5'd14:   bits_nxt[7:0]   = file_byte;
          5'd15:   bits_nxt[15:8]  = file_byte;
          default: ;
        endcase
        if (foff_r < FMT_MIN_BYTES) begin
          foff_nxt = foff_r + 5'd1;
        end
        rem_nxt = rem_dec;
        if (rem_dec == 33'd0) begin
          phase_nxt = PH_TAG;
          fidx_nxt  = 2'd0;
        end
      end
      PH_DATA: begin
        fbuf_nxt[fidx_r] = file_byte;
        if ({1'b0, fidx_r} + 3'd1 >= fbytes_r) begin
          fidx_nxt = 2'd0;
          if (femit_r < max_frames) begin
            smp       = mix_frame(fbuf_nxt, bits_r == 16'd16, chan_r == 16'd2);
            smp_valid = 1'b1;
            femit_nxt = femit_r + 17'd1;
          end
        end else begin
          fidx_nxt = fidx_r + 2'd1;
        end
        rem_nxt = rem_dec;
        if (rem_dec == 33'd0) begin
          phase_nxt = PH_STOP;
        end
      end
      PH_SKIP: begin
        rem_nxt = rem_dec;
        if (rem_dec == 33'd0) begin
          phase_nxt = PH_TAG;
          fidx_nxt  = 2'd0;
        end
      end
      default: ;
    endcase

    if (pos_nxt < MIN_FILE_BYTES) begin
      status = ST_BAD_HEADER;
    end else if (err_nxt != ST_OK) begin
      status = err_nxt;
    end else if (fbytes_nxt == 3'd0 || femit_nxt == '0) begin
      status = ST_NO_SAMPLES;
    end else begin
      status = ST_OK;
    end

    res.has_result   = smp_valid | end_of_file;
    res.sample       = smp;
    res.sample_valid = smp_valid;
    res.done         = end_of_file;
    res.status       = end_of_file ? status : ST_OK;
    res.rate         = end_of_file ? rate_nxt : 32'd0;
    res.count        = end_of_file ? femit_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && end_of_file)) begin
      phase_r  <= PH_RIFF;
      pos_r    <= 6'd0;
      tag_r    <= 32'd0;
      rem_r    <= 33'd0;
      chan_r   <= 16'd0;
      rate_r   <= 32'd0;
      bits_r   <= 16'd0;
      fbytes_r <= 3'd0;
      fidx_r   <= 2'd0;
      femit_r  <= '0;
      err_r    <= ST_OK;
      foff_r   <= 5'd0;
      fbuf_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      tag_r    <= tag_nxt;
      rem_r    <= rem_nxt;
      chan_r   <= chan_nxt;
      rate_r   <= rate_nxt;
      bits_r   <= bits_nxt;
      fbytes_r <= fbytes_nxt;
      fidx_r   <= fidx_nxt;
      femit_r  <= femit_nxt;
      err_r    <= err_nxt;
      foff_r   <= foff_nxt;
      fbuf_r   <= fbuf_nxt;
    end
  end

endmodule

@@ src/wav_to_u8_mono_pcm.sv @@
// ----------------------------------------------------------------------------
// wav_to_u8_mono_pcm
// Streaming RIFF/WAVE PCM decoder giving unsigned 8-bit mono samples.
// ----------------------------------------------------------------------------
// One file byte is taken per cycle while in_ready is high. The parser
// advances its state in the cycle of the request, and any result (a sample,
// the end-of-file report, or both) lands in the output register at the end
// of that cycle. in_ready stays high while that register is empty or being
// read, so bytes stream at one per cycle whenever out_ready keeps up; a byte
// that yields no result occupies no output slot. The parser step and mixer
// are combinational. max_frames, written via cfg_wr_en/cfg_wr_data, resets to
// 65536; the user must write it only while no file is in flight (not enforced).
module wav_to_u8_mono_pcm import wavd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_file_byte,
  input  logic                    in_end_of_file,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_sample,
  output logic                    out_sample_valid,
  output logic                    out_done_res,
  output logic [1:0]              out_status,
  output logic [31:0]             out_rate,
  output logic [MAX_FRAMES_W-1:0] out_frame_total,
  input  logic                    cfg_wr_en,
  input  logic [MAX_FRAMES_W-1:0] cfg_wr_data
);

  logic [MAX_FRAMES_W-1:0] max_frames_r;
  logic                    out_valid_r;
  res_t                    res_r;
  res_t                    res;
  logic                    in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  wavd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .file_byte   (in_file_byte),
    .end_of_file (in_end_of_file),
    .max_frames  (max_frames_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frames_r <= MAX_FRAMES_RST;
    end else if (cfg_wr_en) begin
      max_frames_r <= cfg_wr_data;
    end
  end

  // hold the result until taken, load a new one on each request that yields one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_fire && res.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.has_result) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = res_r.sample;
  assign out_sample_valid = res_r.sample_valid;
  assign out_done_res     = res_r.done;
  assign out_status       = res_r.status;
  assign out_rate         = res_r.rate;
  assign out_frame_total  = res_r.count;

  a_result_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.sample_valid || res_r.done))
    else $error("result without sample or done");

  a_report_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.done) |-> (res_r.status == ST_OK && res_r.count == '0))
    else $error("report fields set without done");

  a_count_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.done) |-> (res_r.count <= max_frames_r))
    else $error("frame count above max_frames");

  a_sample_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.sample_valid) |-> (res_r.sample == 8'd0))
    else $error("sample set without sample_valid");

endmodule
